@@ hw/rtl/prl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prl_pkg : shared types and constants
// Opcodes, status codes, word field widths and the record payload type for
// the positional record list.
// ----------------------------------------------------------------------------
package prl_pkg;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 8;
    localparam int KEY_W    = 64;
    localparam int NAME_W   = 64;
    localparam int ROLE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE    = 1'b0,
        S_RESOLVE = 1'b1
    } t_state;

    // name and role of one record; the identifier travels separately
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [ROLE_W-1:0] role;
    } t_payload;

    // per-cell control for one cycle
    typedef struct packed {
        logic take_prev;   // shift up: copy neighbour below
        logic take_next;   // shift down: copy neighbour above
        logic load;        // write the incoming record
        logic seek;        // capture compare result
        logic live;        // cell holds a record
    } t_cell_ctl;

endpackage : prl_pkg
`default_nettype wire

@@ hw/rtl/prl_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prl_cmd_if / prl_rsp_if : command and response channels
// Valid/ready channels carrying one command word and one response word.
// ----------------------------------------------------------------------------
interface prl_cmd_if;
    import prl_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    entry_key;
    logic [NAME_W-1:0]   entry_name;
    logic [ROLE_W-1:0]   entry_role;

    modport source (
        output valid, opcode, position, entry_key, entry_name, entry_role,
        input  ready
    );
    modport sink (
        input  valid, opcode, position, entry_key, entry_name, entry_role,
        output ready
    );
endinterface : prl_cmd_if

interface prl_rsp_if;
    import prl_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [COUNT_W-1:0]  entry_count;

    modport source (
        output valid, status, found_position, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_position, entry_count,
        output ready
    );
endinterface : prl_rsp_if
`default_nettype wire

@@ hw/rtl/prl_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prl_cell : one slot of the record chain
// Holds one record, shifts from either neighbour or loads a new record, and
// registers an identifier match for find.
// ----------------------------------------------------------------------------
module prl_cell #(
    parameter int IDW = 64
) (
    input  wire logic               i_clk,
    input  wire prl_pkg::t_cell_ctl i_ctl,
    input  wire logic [IDW-1:0]     i_new_id,
    input  wire prl_pkg::t_payload  i_new_pay,
    input  wire logic [IDW-1:0]     i_prev_id,
    input  wire prl_pkg::t_payload  i_prev_pay,
    input  wire logic [IDW-1:0]     i_next_id,
    input  wire prl_pkg::t_payload  i_next_pay,
    input  wire logic [IDW-1:0]     i_key,
    output logic [IDW-1:0]          o_id,
    output prl_pkg::t_payload       o_pay,
    output logic                    o_hit
);
    import prl_pkg::*;

    logic [IDW-1:0] r_id;
    t_payload       r_pay;
    logic           r_hit;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load) begin
            r_id  <= i_new_id;
            r_pay <= i_new_pay;
        end else if (i_ctl.take_prev) begin
            r_id  <= i_prev_id;
            r_pay <= i_prev_pay;
        end else if (i_ctl.take_next) begin
            r_id  <= i_next_id;
            r_pay <= i_next_pay;
        end else begin
            r_id  <= r_id;
            r_pay <= r_pay;
        end
        if (i_ctl.seek) begin
            r_hit <= i_ctl.live && (r_id == i_key);
        end
    end

    assign o_id  = r_id;
    assign o_pay = r_pay;
    assign o_hit = r_hit;

endmodule : prl_cell
`default_nettype wire

@@ hw/rtl/positional_record_list_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_record_list_top : ordered record list on a shifting cell chain
// Insert/delete at a position and find-by-identifier over up to DEPTH records.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | word
//  --------+-----+-----------------+---------------------------------------------
//  i_cmd   | in  | valid / ready   | opcode, position, entry_key, name, role
//  o_rsp   | out | valid / ready   | status, found_position, entry_count
//
//  Each command word passes the S_IDLE and S_RESOLVE states in turn: the
//  accept edge updates the chain and the count, and S_RESOLVE resolves find
//  from the registered match bits through a priority encoder and loads the
//  response register. A new word is taken while the previous response waits,
//  as long as that response is taken in the same cycle or has already gone.
//  Reset (synchronous, active low) empties the list at once; record contents
//  need no clearing as only positions below the count are ever read.
// ----------------------------------------------------------------------------
module positional_record_list_top #(
    parameter int DEPTH    = 16,
    parameter int ID_CHARS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    prl_cmd_if.sink   i_cmd,
    prl_rsp_if.source o_rsp
);
    import prl_pkg::*;

    localparam int IDW = 8 * ID_CHARS;          // stored identifier width
    localparam int IW  = $clog2(DEPTH);         // cell index width
    localparam int CW  = $clog2(DEPTH + 1);     // count width

    // control
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_status         r_status, n_status;        // status of the last word
    logic            r_seek;                    // last word was a find
    logic            w_accept;
    logic            w_op_ok;                   // insert / delete goes ahead
    t_opcode         w_op;
    logic [COUNT_W-1:0] w_pos_x;                // position widened for compare
    logic [COUNT_W-1:0] w_cnt_x;

    // response register
    logic            r_rsp_valid, n_rsp_valid;
    t_status         r_rsp_status, n_rsp_status;
    logic [POS_W-1:0] r_rsp_fp, n_rsp_fp;
    logic [COUNT_W-1:0] r_rsp_count, n_rsp_count;

    // chain
    t_cell_ctl       w_ctl [DEPTH];
    logic [IDW-1:0]  w_id  [DEPTH];
    t_payload        w_pay [DEPTH];
    logic [DEPTH-1:0] w_hit;
    logic [IDW-1:0]  w_key;
    t_payload        w_new_pay;
    logic            w_any_hit;
    logic [IW-1:0]   w_first;

    assign w_op      = t_opcode'(i_cmd.opcode);
    assign w_pos_x   = COUNT_W'(i_cmd.position);
    assign w_cnt_x   = COUNT_W'(r_count);
    assign w_key     = i_cmd.entry_key[IDW-1:0];
    assign w_new_pay = '{name: i_cmd.entry_name, role: i_cmd.entry_role};

    // ---- command decode: status and count against the current list ----
    always_comb begin
        n_status = ST_OK;
        w_op_ok  = 1'b0;
        n_count  = r_count;
        unique case (w_op)
            OP_INSERT: begin
                priority if (r_count == CW'(DEPTH)) n_status = ST_FULL;
                else if (w_pos_x > w_cnt_x)        n_status = ST_BADPOS;
                else begin
                    w_op_ok = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                priority if (r_count == '0)         n_status = ST_EMPTY;
                else if (w_pos_x >= w_cnt_x)       n_status = ST_BADPOS;
                else begin
                    w_op_ok = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_FIND: begin
                // match result settles in the resolve cycle
                if (r_count == '0) n_status = ST_EMPTY;
            end
            OP_NONE: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // ---- per-cell control: each cell compares its own place with position ----
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ctl
        localparam logic [COUNT_W-1:0] IDX = COUNT_W'(gi);
        always_comb begin
            w_ctl[gi].load      = w_accept && w_op_ok && (w_op == OP_INSERT)
                                  && (IDX == w_pos_x);
            w_ctl[gi].take_prev = w_accept && w_op_ok && (w_op == OP_INSERT)
                                  && (IDX > w_pos_x);
            w_ctl[gi].take_next = w_accept && w_op_ok && (w_op == OP_DELETE)
                                  && (IDX >= w_pos_x) && (gi < DEPTH - 1);
            w_ctl[gi].seek      = w_accept && (w_op == OP_FIND);
            w_ctl[gi].live      = IDX < w_cnt_x;
        end
    end

    // ---- the chain; end cells see themselves as the missing neighbour ----
    for (genvar gc = 0; gc < DEPTH; gc++) begin : g_cell
        localparam int PREV = (gc == 0) ? 0 : gc - 1;
        localparam int NEXT = (gc == DEPTH - 1) ? gc : gc + 1;
        prl_cell #(
            .IDW (IDW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[gc]),
            .i_new_id   (w_key),
            .i_new_pay  (w_new_pay),
            .i_prev_id  (w_id[PREV]),
            .i_prev_pay (w_pay[PREV]),
            .i_next_id  (w_id[NEXT]),
            .i_next_pay (w_pay[NEXT]),
            .i_key      (w_key),
            .o_id       (w_id[gc]),
            .o_pay      (w_pay[gc]),
            .o_hit      (w_hit[gc])
        );
    end

    // ---- lowest matching position from the registered hit bits ----
    always_comb begin
        w_first = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (w_hit[k]) w_first = IW'(k);
        end
    end
    assign w_any_hit = |w_hit;

    // ---- sequencer ----
    always_comb begin
        n_state      = r_state;
        w_accept     = 1'b0;
        i_cmd.ready  = 1'b0;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_rsp_status = r_rsp_status;
        n_rsp_fp     = r_rsp_fp;
        n_rsp_count  = r_rsp_count;
        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = !r_rsp_valid || o_rsp.ready;
                w_accept    = i_cmd.valid && i_cmd.ready;
                if (w_accept) n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                // the response register is free here: accept needed it so
                n_rsp_valid  = 1'b1;
                n_rsp_count  = COUNT_W'(r_count);
                n_rsp_fp     = '0;
                n_rsp_status = r_status;
                if (r_seek && r_status == ST_OK) begin
                    if (w_any_hit) begin
                        n_rsp_fp = POS_W'(w_first);
                    end else begin
                        n_rsp_status = ST_NOTFOUND;
                    end
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= w_accept ? n_count : r_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_seek   <= (w_op == OP_FIND);
        end
        r_rsp_status <= n_rsp_status;
        r_rsp_fp     <= n_rsp_fp;
        r_rsp_count  <= n_rsp_count;
    end

    assign o_rsp.valid          = r_rsp_valid;
    assign o_rsp.status         = r_rsp_status;
    assign o_rsp.found_position = r_rsp_fp;
    assign o_rsp.entry_count    = r_rsp_count;

    // ---- checks ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("record count above depth");

    a_rsp_from_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state == S_RESOLVE))
        else $error("response appeared without a resolve cycle");

    a_resolve_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE) |=> (r_state == S_IDLE) && r_rsp_valid)
        else $error("resolve did not load the response");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op_ok && w_op == OP_INSERT) |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    a_find_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_FIND) |=> $stable(r_count))
        else $error("find changed the count");

endmodule : positional_record_list_top
`default_nettype wire
